[hdl/source_text_tokenizer_assert.svh]
// Assertion macros used by the source_text_tokenizer module.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define STT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked on the clock edge after the antecedent.
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stt_pkg.sv]
package stt_pkg;

  // Token kinds.
  localparam logic [5:0] KindNumber = 6'd0;
  localparam logic [5:0] KindBool   = 6'd1;
  localparam logic [5:0] KindString = 6'd13;
  localparam logic [5:0] KindIdent  = 6'd25;
  localparam logic [5:0] KindSlash  = 6'd31;
  localparam logic [5:0] KindEnd    = 6'd40;
  localparam logic [5:0] KindErr    = 6'd41;

  // Scanner states.
  localparam logic [6:0] StIdle    = 7'd0;
  localparam logic [6:0] StInt     = 7'd1;
  localparam logic [6:0] StDotLead = 7'd2;
  localparam logic [6:0] StDotMid  = 7'd3;
  localparam logic [6:0] StFrac    = 7'd4;
  localparam logic [6:0] StIdent   = 7'd5;
  localparam logic [6:0] StDq      = 7'd6;
  localparam logic [6:0] StDqEsc   = 7'd7;
  localparam logic [6:0] StSq      = 7'd8;
  localparam logic [6:0] StSqEsc   = 7'd9;
  localparam logic [6:0] StComment = 7'd10;
  localparam logic [6:0] StOp      = 7'd11;
  localparam logic [6:0] StKw      = 7'd21;

  localparam int NumOps = 10;
  localparam int NumKw  = 13;
  localparam int KwMax  = 6;

  // Result item at internal widths (32 bits cover every parameter value).
  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] line;
    logic [31:0] column;
    logic [31:0] offset;
    logic [31:0] length;
  } result_t;

  typedef struct packed {
    logic [1:0]  count;
    result_t     r0;
    result_t     r1;
  } step_out_t;

  // Keyword characters, index k then position j.
  function automatic logic [7:0] kw_char(input int k, input int j);
    logic [47:0] s;
    case (k)
      0:  s = "true  ";
      1:  s = "false ";
      2:  s = "Array ";
      3:  s = "int   ";
      4:  s = "float ";
      5:  s = "char  ";
      6:  s = "bool  ";
      7:  s = "if    ";
      8:  s = "else  ";
      9:  s = "for   ";
      10: s = "while ";
      11: s = "func  ";
      default: s = "ret   ";
    endcase
    return s[47-8*j -: 8];
  endfunction

  function automatic int kw_len(input int k);
    case (k)
      0: return 4; 1: return 5; 2: return 5; 3: return 3; 4: return 5;
      5: return 4; 6: return 4; 7: return 2; 8: return 4; 9: return 3;
      10: return 5; 11: return 4; default: return 3;
    endcase
  endfunction

  function automatic logic [5:0] kw_kind(input int k);
    return (k == 0) ? KindBool : 6'(k);
  endfunction

  function automatic logic [7:0] op_first(input int i);
    case (i)
      0: return "="; 1: return ">"; 2: return "<"; 3: return "!"; 4: return "+";
      5: return "-"; 6: return ":"; 7: return "|"; 8: return "&"; default: return "/";
    endcase
  endfunction

  function automatic logic [7:0] op_second(input int i);
    case (i)
      0, 1, 2, 3, 4, 5: return "=";
      6: return ":"; 7: return "|"; 8: return "&"; default: return "/";
    endcase
  endfunction

  function automatic logic [5:0] op_pair(input int i);
    case (i)
      0: return 6'd14; 1: return 6'd15; 2: return 6'd16; 3: return 6'd17;
      4: return 6'd21; 5: return 6'd22; 6: return 6'd24; 7: return 6'd26;
      default: return 6'd27;
    endcase
  endfunction

  function automatic logic [5:0] op_single(input int i);
    case (i)
      0: return 6'd23; 1: return 6'd18; 2: return 6'd19; 3: return 6'd20;
      4: return 6'd28; 5: return 6'd29; 9: return KindSlash;
      default: return KindErr;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  // Lowest keyword sharing keyword k's first j bytes with byte j equal to c.
  function automatic int kw_next(input int k, input int j, input logic [7:0] c);
    int res;
    logic same;
    res = -1;
    for (int m = NumKw - 1; m >= 0; m--) begin
      same = 1'b1;
      for (int i = 0; i < KwMax; i++) begin
        if (i < j && k >= 0 && kw_char(m, i) != kw_char(k, i)) same = 1'b0;
      end
      if (kw_len(m) > j && same && kw_char(m, j) == c) res = m;
    end
    return res;
  endfunction

endpackage

[hdl/stt_if.sv]
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;
  modport source (output valid, char_code, end_of_text, input ready);
  modport sink (input valid, char_code, end_of_text, output ready);
endinterface

interface stt_out_if #(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int OFFSET_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic [5:0]             token_kind;
  logic [LINE_BITS-1:0]   start_line;
  logic [COLUMN_BITS-1:0] start_column;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [OFFSET_BITS-1:0] token_length;
  logic                   last_of_run;
  modport source (output valid, token_kind, start_line, start_column, start_offset,
                  token_length, last_of_run, input ready);
  modport sink (input valid, token_kind, start_line, start_column, start_offset,
                token_length, last_of_run, output ready);
endinterface

[hdl/stt_scanner.sv]
// Scanner: holds the lexer state and counters and turns one byte into up to
// three result items combinationally.
module stt_scanner #(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int OFFSET_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         char_i,
  input  logic               eot_i,
  output logic [1:0]         count_o,
  output stt_pkg::result_t   res_o [3],
  output logic               halted_o
);

  localparam logic [31:0] LineMax = 32'((64'd1 << LINE_BITS) - 1);
  localparam logic [31:0] ColMax  = 32'((64'd1 << COLUMN_BITS) - 1);
  localparam logic [31:0] OffMax  = 32'((64'd1 << OFFSET_BITS) - 1);

  logic [6:0]  state_q, state_d;
  logic [5:0]  okind_q, okind_d;
  logic [31:0] oline_q, oline_d, ocol_q, ocol_d, ooff_q, ooff_d;
  logic [31:0] off_q, off_d, line_q, line_d, col_q, col_d;
  logic        halted_q, halted_d;

  function automatic logic [31:0] span(input logic [31:0] a, input logic [31:0] b);
    return (b > a) ? b - a : 32'd0;
  endfunction

  function automatic logic [5:0] word_kind(input logic [6:0] s);
    logic [5:0] k;
    k = stt_pkg::KindIdent;
    for (int m = 0; m < stt_pkg::NumKw; m++) begin
      if (s == 7'(int'(stt_pkg::StKw) + m * 6 + stt_pkg::kw_len(m)))
        k = stt_pkg::kw_kind(m);
    end
    return k;
  endfunction

  // Next-state and result logic for one byte.
  always_comb begin
    logic [31:0] ln, cl, pos, dot;
    logic [7:0]  c;
    logic [1:0]  n;
    stt_pkg::result_t r [3];
    logic        want_begin, dfail, halt;
    logic [31:0] fl, fc, fo;
    logic [31:0] eoff;
    int          kk, mm;
    logic        fail_now;

    c = char_i;
    ln = line_q; cl = col_q; pos = off_q;
    state_d = state_q; okind_d = okind_q;
    oline_d = oline_q; ocol_d = ocol_q; ooff_d = ooff_q;
    halt = halted_q;
    n = 2'd0;
    for (int i = 0; i < 3; i++) r[i] = '0;
    want_begin = 1'b0;
    dfail = 1'b0;
    fail_now = 1'b0;
    fl = oline_q; fc = ocol_q; fo = ooff_q;
    dot = (pos > 0) ? pos - 32'd1 : 32'd0;
    eoff = off_q;
    kk = 0; mm = -1;

    // Consume the byte in the current state.
    if (state_q == stt_pkg::StIdle) begin
      want_begin = 1'b1;
    end else if (state_q == stt_pkg::StInt || state_q == stt_pkg::StFrac) begin
      if (stt_pkg::is_digit(c)) begin
      end else if (state_q == stt_pkg::StInt && c == ".") begin
        state_d = stt_pkg::StDotMid;
      end else begin
        r[n] = '{stt_pkg::KindNumber, oline_q, ocol_q, ooff_q, span(ooff_q, pos)};
        n = n + 2'd1;
        want_begin = 1'b1;
      end
    end else if (state_q == stt_pkg::StDotLead) begin
      if (stt_pkg::is_digit(c)) state_d = stt_pkg::StFrac;
      else fail_now = 1'b1;
    end else if (state_q == stt_pkg::StDotMid) begin
      if (stt_pkg::is_digit(c)) state_d = stt_pkg::StFrac;
      else dfail = 1'b1;
    end else if (state_q == stt_pkg::StDq || state_q == stt_pkg::StSq) begin
      if (c == ((state_q == stt_pkg::StDq) ? 8'h22 : 8'h27)) begin
        r[n] = '{stt_pkg::KindString, oline_q, ocol_q, ooff_q, span(ooff_q, pos + 32'd1)};
        n = n + 2'd1;
        state_d = stt_pkg::StIdle;
      end else if (c == 8'h5c) begin
        state_d = state_q + 7'd1;
      end
    end else if (state_q == stt_pkg::StDqEsc || state_q == stt_pkg::StSqEsc) begin
      state_d = state_q - 7'd1;
    end else if (state_q == stt_pkg::StComment) begin
      if (c == 8'h0a) state_d = stt_pkg::StIdle;
    end else if (state_q >= stt_pkg::StOp && state_q < stt_pkg::StKw - 7'd0
                 && state_q < 7'(int'(stt_pkg::StOp) + stt_pkg::NumOps)) begin
      for (int i = 0; i < stt_pkg::NumOps; i++) begin
        if (state_q == 7'(int'(stt_pkg::StOp) + i)) kk = i;
      end
      if (c == stt_pkg::op_second(kk)) begin
        if (kk == stt_pkg::NumOps - 1) begin
          state_d = stt_pkg::StComment;
        end else begin
          r[n] = '{stt_pkg::op_pair(kk), oline_q, ocol_q, ooff_q, 32'd2};
          n = n + 2'd1;
          state_d = stt_pkg::StIdle;
        end
      end else if (okind_q == stt_pkg::KindErr) begin
        fail_now = 1'b1;
      end else begin
        r[n] = '{okind_q, oline_q, ocol_q, ooff_q, 32'd1};
        n = n + 2'd1;
        want_begin = 1'b1;
      end
    end else begin
      // Identifier or keyword prefix.
      if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c)) begin
        state_d = stt_pkg::StIdent;
        for (int k = 0; k < stt_pkg::NumKw; k++) begin
          for (int j = 0; j < stt_pkg::KwMax; j++) begin
            if (state_q == 7'(int'(stt_pkg::StKw) + k * 6 + j)) begin
              mm = stt_pkg::kw_next(k, j, c);
              if (mm >= 0) state_d = 7'(int'(stt_pkg::StKw) + mm * 6 + j + 1);
            end
          end
        end
      end else begin
        r[n] = '{word_kind(state_q), oline_q, ocol_q, ooff_q, span(ooff_q, pos)};
        n = n + 2'd1;
        want_begin = 1'b1;
      end
    end

    // Start a new token at this byte.
    if (want_begin) begin
      state_d = stt_pkg::StIdle;
      if (c != 8'h20 && c != 8'h09 && c != 8'h0a) begin
        oline_d = ln; ocol_d = cl; ooff_d = pos;
        fl = ln; fc = cl; fo = pos;
        if (stt_pkg::is_digit(c)) begin
          state_d = stt_pkg::StInt; okind_d = stt_pkg::KindNumber;
        end else if (c == ".") begin
          state_d = stt_pkg::StDotLead; okind_d = stt_pkg::KindNumber;
        end else if (stt_pkg::is_alpha(c)) begin
          mm = stt_pkg::kw_next(-1, 0, c);
          state_d = (mm < 0) ? stt_pkg::StIdent : 7'(int'(stt_pkg::StKw) + mm * 6 + 1);
          okind_d = stt_pkg::KindIdent;
        end else if (c == 8'h22) begin
          state_d = stt_pkg::StDq; okind_d = stt_pkg::KindString;
        end else if (c == 8'h27) begin
          state_d = stt_pkg::StSq; okind_d = stt_pkg::KindString;
        end else begin
          fail_now = 1'b1;
          for (int i = stt_pkg::NumOps - 1; i >= 0; i--) begin
            if (c == stt_pkg::op_first(i)) begin
              fail_now = 1'b0;
              state_d = 7'(int'(stt_pkg::StOp) + i);
              okind_d = stt_pkg::op_single(i);
            end
          end
          case (c)
            "*": begin r[n] = '{6'd30, ln, cl, pos, 32'd1}; fail_now = 1'b0; end
            "(": begin r[n] = '{6'd32, ln, cl, pos, 32'd1}; fail_now = 1'b0; end
            ")": begin r[n] = '{6'd33, ln, cl, pos, 32'd1}; fail_now = 1'b0; end
            "{": begin r[n] = '{6'd34, ln, cl, pos, 32'd1}; fail_now = 1'b0; end
            "}": begin r[n] = '{6'd35, ln, cl, pos, 32'd1}; fail_now = 1'b0; end
            "[": begin r[n] = '{6'd36, ln, cl, pos, 32'd1}; fail_now = 1'b0; end
            "]": begin r[n] = '{6'd37, ln, cl, pos, 32'd1}; fail_now = 1'b0; end
            ";": begin r[n] = '{6'd38, ln, cl, pos, 32'd1}; fail_now = 1'b0; end
            ",": begin r[n] = '{6'd39, ln, cl, pos, 32'd1}; fail_now = 1'b0; end
            default: ;
          endcase
          if (!fail_now && state_d == stt_pkg::StIdle) n = n + 2'd1;
        end
      end
    end

    // Digits then a bare dot: emit the number, fail at the dot.
    if (dfail) begin
      r[n] = '{stt_pkg::KindNumber, oline_q, ocol_q, ooff_q, span(ooff_q, dot)};
      n = n + 2'd1;
      fl = ln; fc = (cl > 1) ? cl - 32'd1 : 32'd1; fo = dot;
      fail_now = 1'b1;
    end
    if (fail_now) begin
      r[n] = '{stt_pkg::KindErr, fl, fc, fo, 32'd0};
      n = n + 2'd1;
      halt = 1'b1;
      state_d = stt_pkg::StIdle;
    end

    // Counter update.
    if (c == 8'h0a) begin
      line_d = (line_q < LineMax) ? line_q + 32'd1 : line_q;
      col_d = 32'd1;
    end else begin
      line_d = line_q;
      col_d = (col_q < ColMax) ? col_q + 32'd1 : col_q;
    end
    off_d = (off_q < OffMax) ? off_q + 32'd1 : off_q;
    eoff = off_d;

    // End of text: close the open token, then the end token unless that failed.
    if (!halt && eot_i) begin
      if (state_d == stt_pkg::StInt || state_d == stt_pkg::StFrac) begin
        r[n] = '{stt_pkg::KindNumber, oline_d, ocol_d, ooff_d, span(ooff_d, eoff)};
        n = n + 2'd1;
      end else if (state_d == stt_pkg::StDotMid) begin
        dot = (eoff > 0) ? eoff - 32'd1 : 32'd0;
        r[n] = '{stt_pkg::KindNumber, oline_d, ocol_d, ooff_d, span(ooff_d, dot)};
        n = n + 2'd1;
        r[n] = '{stt_pkg::KindErr, line_d, (col_d > 1) ? col_d - 32'd1 : 32'd1, dot, 32'd0};
        n = n + 2'd1;
        halt = 1'b1;
      end else if (state_d == stt_pkg::StDotLead ||
                   (state_d >= stt_pkg::StDq && state_d <= stt_pkg::StSqEsc)) begin
        r[n] = '{stt_pkg::KindErr, oline_d, ocol_d, ooff_d, 32'd0};
        n = n + 2'd1;
        halt = 1'b1;
      end else if (state_d >= stt_pkg::StOp &&
                   state_d < 7'(int'(stt_pkg::StOp) + stt_pkg::NumOps)) begin
        r[n] = '{okind_d, oline_d, ocol_d, ooff_d,
                 (okind_d == stt_pkg::KindErr) ? 32'd0 : 32'd1};
        n = n + 2'd1;
        if (okind_d == stt_pkg::KindErr) halt = 1'b1;
      end else if (state_d == stt_pkg::StIdent || state_d >= stt_pkg::StKw) begin
        r[n] = '{word_kind(state_d), oline_d, ocol_d, ooff_d, span(ooff_d, eoff)};
        n = n + 2'd1;
      end
      if (!halt) begin
        r[n] = '{stt_pkg::KindEnd, line_d, col_d, eoff, 32'd0};
        n = n + 2'd1;
      end
      halt = 1'b1;
      state_d = stt_pkg::StIdle;
    end

    halted_d = halt;
    count_o = halted_q ? 2'd0 : n;
    for (int i = 0; i < 3; i++) res_o[i] = r[i];
  end

  assign halted_o = halted_q;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stt_pkg::StIdle;
      okind_q <= stt_pkg::KindNumber;
      oline_q <= 32'd1; ocol_q <= 32'd1; ooff_q <= '0;
      off_q <= '0; line_q <= 32'd1; col_q <= 32'd1;
      halted_q <= 1'b0;
    end else if (step_i && !halted_q) begin
      state_q <= state_d; okind_q <= okind_d;
      oline_q <= oline_d; ocol_q <= ocol_d; ooff_q <= ooff_d;
      off_q <= off_d; line_q <= line_d; col_q <= col_d;
      halted_q <= halted_d;
    end
  end

endmodule

[hdl/source_text_tokenizer.sv]
// Source text tokenizer.
// Input channel in_i carries one source byte per transaction (char_code) and
// end_of_text on the final byte. Output channel out_o carries result
// transactions: token kind, start line, column, offset, length and
// last_of_run, which marks the final result caused by one byte.
// A byte is scanned in the cycle it is accepted; its zero to three results
// are registered in a small result queue. One byte is accepted per cycle
// as long as the queue has room for three more results, so a stalled
// receiver holds the input off only once the queue fills; results go out
// one per cycle while the receiver is ready, so throughput is one byte
// per cycle up to the one-result-per-cycle limit of the output port.
// At reset the position is line 1, column 1, offset 0 and the queue is empty.
// After the end token or an error result the block accepts bytes but gives
// no further results until the next reset.
module source_text_tokenizer #(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int OFFSET_BITS = 24
) (
  input logic clk_i,
  input logic rst_ni,
  stt_in_if.sink   in_i,
  stt_out_if.source out_o
);

  `include "source_text_tokenizer_assert.svh"

  localparam int QDepth = 8;

  logic [1:0]       count;
  stt_pkg::result_t res [3];
  logic             halted;
  logic             take;

  stt_pkg::result_t q_mem [QDepth];
  logic             q_last [QDepth];
  logic [2:0]       wr_q, rd_q;
  logic [3:0]       fill_q;

  assign in_i.ready = (fill_q <= 4'(QDepth - 3));
  assign take = in_i.valid && in_i.ready;

  stt_scanner #(
    .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .OFFSET_BITS(OFFSET_BITS)
  ) u_scanner (
    .clk_i, .rst_ni, .step_i(take), .char_i(in_i.char_code), .eot_i(in_i.end_of_text),
    .count_o(count), .res_o(res), .halted_o(halted)
  );

  logic [1:0] n_in;
  logic       pop;
  assign n_in = take ? count : 2'd0;
  assign pop = out_o.valid && out_o.ready;

  // Result queue.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n_in) begin
        q_mem[wr_q + 3'(i)]  <= res[i];
        q_last[wr_q + 3'(i)] <= (2'(i) == n_in - 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; fill_q <= '0;
    end else begin
      wr_q <= wr_q + 3'(n_in);
      rd_q <= rd_q + 3'(pop);
      fill_q <= fill_q + 4'(n_in) - 4'(pop);
    end
  end

  assign out_o.valid        = (fill_q != 4'd0);
  assign out_o.token_kind   = q_mem[rd_q].kind;
  assign out_o.start_line   = q_mem[rd_q].line[LINE_BITS-1:0];
  assign out_o.start_column = q_mem[rd_q].column[COLUMN_BITS-1:0];
  assign out_o.start_offset = q_mem[rd_q].offset[OFFSET_BITS-1:0];
  assign out_o.token_length = q_mem[rd_q].length[OFFSET_BITS-1:0];
  assign out_o.last_of_run  = q_last[rd_q];

  `STT_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= 4'(QDepth), "queue overflow")
  `STT_ASSERT_IMP(a_halt_quiet, clk_i, rst_ni, halted, count == 2'd0, "result after halt")
  `STT_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halted, halted, "halt cleared")

endmodule

[bench/tb_source_text_tokenizer.sv]
`timescale 1ns / 100ps

module tb_source_text_tokenizer;

  localparam int unsigned LineMax   = (1 << 20) - 1;
  localparam int unsigned ColumnMax = (1 << 16) - 1;
  localparam int unsigned OffsetMax = (1 << 24) - 1;
  localparam logic [5:0]  PairComment = 6'd63;
  localparam int          WatchdogLimit = 4000;
  localparam int          SourceBytes = 330;

  typedef enum int {
    M_IDLE, M_INT, M_DOTLEAD, M_DOTMID, M_FRAC, M_WORD,
    M_DQ, M_DQESC, M_SQ, M_SQESC, M_COMMENT, M_OP
  } scan_mode_e;

  typedef struct {
    logic [5:0]  kind;
    logic [19:0] line;
    logic [15:0] column;
    logic [23:0] offset;
    logic [23:0] length;
    logic        last;
  } token_t;

  typedef struct {
    byte unsigned code;
    bit           last;
    int           row;
  } src_byte_t;

  // Directed source fragments with the kind and length of the first token each one yields.
  typedef struct {
    string      text;
    logic [5:0] first_kind;
    int         first_len;
  } fragment_t;

  logic clk;
  logic rst_n;
  stt_in_if  in_bus ();
  stt_out_if out_bus ();

  source_text_tokenizer uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  string      kw_word [13] = '{"true", "false", "Array", "int", "float", "char", "bool",
                               "if", "else", "for", "while", "func", "ret"};
  logic [5:0] kw_kinds [13] = '{stt_pkg::KindBool, stt_pkg::KindBool, 6'd2, 6'd3, 6'd4,
                               6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12};
  string      op_lead = "=><!+-:|&/";
  string      op_tail = "======:|&/";
  logic [5:0] op_pair_kind [10] = '{6'd14, 6'd15, 6'd16, 6'd17, 6'd21, 6'd22, 6'd24,
                                   6'd26, 6'd27, PairComment};
  logic [5:0] op_lone_kind [10] = '{6'd23, 6'd18, 6'd19, 6'd20, 6'd28, 6'd29,
                                   stt_pkg::KindErr, stt_pkg::KindErr, stt_pkg::KindErr,
                                   stt_pkg::KindSlash};
  string      punct_chars = "*(){}[];,";
  logic [5:0] punct_kind [9] = '{6'd30, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37,
                                6'd38, 6'd39};

  fragment_t fragments [] = '{
    '{"ab ", stt_pkg::KindIdent, 2},
    '{"true false true1 ", stt_pkg::KindBool, 4},
    '{"Array int float char bool ", 6'd2, 5},
    '{"if else for while func ret _Z9 ", 6'd7, 2},
    '{"0 99999999 ", stt_pkg::KindNumber, 1},
    '{"4.56 .5 12.0 ", stt_pkg::KindNumber, 4},
    '{"\"s\\\"x\" ", stt_pkg::KindString, 6},
    '{"'q\\n' ", stt_pkg::KindString, 5},
    '{"== >= <= != ", 6'd14, 2},
    '{"> < ! += -= ", 6'd18, 1},
    '{"= :: || && ", 6'd23, 1},
    '{"+ - * / ", 6'd28, 1},
    '{"( ) { } ", 6'd32, 1},
    '{"[ ] ; , ", 6'd36, 1},
    '{"x// note\n", stt_pkg::KindIdent, 1},
    '{"p\tq\nr+1 ", stt_pkg::KindIdent, 1}
  };

  // Tokenizer state mirrored by the predictor.
  scan_mode_e  mode;
  int          kw_id, kw_pos, op_id;
  logic [5:0]  open_kind;
  int unsigned open_line, open_column, open_offset;
  int unsigned pos_line, pos_column, pos_offset;
  bit          halted;
  token_t      step_tokens[$];
  token_t      pending_tokens[$];
  src_byte_t   source_bytes[$];
  bit          row_checked [int];

  int  errors = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_receiver = 0;
  bit  sender_done = 0;
  int  quiet_cycles = 0;
  int  accepted_bytes = 0;

  function automatic bit is_digit_c(int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha_c(int c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic int unsigned span_of(int unsigned a, int unsigned b);
    return b > a ? b - a : 0;
  endfunction

  // Lowest keyword sharing the first j bytes of keyword k and having byte c at j.
  function automatic int kw_follow(int k, int j, int c);
    bit same;
    for (int m = 0; m < 13; m++) begin
      if (kw_word[m].len() <= j) continue;
      same = 1;
      for (int i = 0; i < j && k >= 0; i++) begin
        if (kw_word[m][i] != kw_word[k][i]) same = 0;
      end
      if (same && kw_word[m][j] == c) return m;
    end
    return -1;
  endfunction

  function automatic logic [5:0] word_kind();
    if (kw_id >= 0 && kw_pos == kw_word[kw_id].len()) return kw_kinds[kw_id];
    return stt_pkg::KindIdent;
  endfunction

  task automatic put_token(logic [5:0] kind, int unsigned ln, int unsigned cl,
                           int unsigned off, int unsigned len);
    token_t t;
    if (step_tokens.size() >= 3) return;
    t.kind = kind;
    t.line = ln[19:0];
    t.column = cl[15:0];
    t.offset = off[23:0];
    t.length = len[23:0];
    t.last = 0;
    step_tokens.push_back(t);
  endtask

  task automatic stop_at(int unsigned ln, int unsigned cl, int unsigned off);
    put_token(stt_pkg::KindErr, ln, cl, off, 0);
    halted = 1;
    mode = M_IDLE;
  endtask

  // Digits, a dot and no digit: the number closes before the dot, which is unmatched.
  task automatic dot_stop(int unsigned ln, int unsigned cl, int unsigned pos);
    int unsigned dot;
    dot = pos > 0 ? pos - 1 : 0;
    put_token(stt_pkg::KindNumber, open_line, open_column, open_offset,
              span_of(open_offset, dot));
    stop_at(ln, cl > 1 ? cl - 1 : 1, dot);
  endtask

  task automatic open_token(int c, int unsigned ln, int unsigned cl, int unsigned pos);
    mode = M_IDLE;
    if (c == " " || c == "\t" || c == "\n") return;
    open_line = ln;
    open_column = cl;
    open_offset = pos;
    if (is_digit_c(c)) begin
      mode = M_INT;
      open_kind = stt_pkg::KindNumber;
      return;
    end
    if (c == ".") begin
      mode = M_DOTLEAD;
      open_kind = stt_pkg::KindNumber;
      return;
    end
    if (is_alpha_c(c)) begin
      kw_id = kw_follow(-1, 0, c);
      kw_pos = kw_id < 0 ? 0 : 1;
      mode = M_WORD;
      open_kind = stt_pkg::KindIdent;
      return;
    end
    if (c == "\"" || c == "'") begin
      mode = c == "\"" ? M_DQ : M_SQ;
      open_kind = stt_pkg::KindString;
      return;
    end
    for (int i = 0; i < 10; i++) begin
      if (c == op_lead[i]) begin
        mode = M_OP;
        op_id = i;
        open_kind = op_lone_kind[i];
        return;
      end
    end
    for (int i = 0; i < 9; i++) begin
      if (c == punct_chars[i]) begin
        put_token(punct_kind[i], ln, cl, pos, 1);
        return;
      end
    end
    stop_at(ln, cl, pos);
  endtask

  task automatic consume_byte(int c);
    int unsigned ln, cl, pos;
    int m;
    ln = pos_line;
    cl = pos_column;
    pos = pos_offset;
    case (mode)
      M_IDLE: open_token(c, ln, cl, pos);
      M_INT, M_FRAC: begin
        if (is_digit_c(c)) return;
        if (mode == M_INT && c == ".") begin
          mode = M_DOTMID;
          return;
        end
        put_token(stt_pkg::KindNumber, open_line, open_column, open_offset,
                  span_of(open_offset, pos));
        open_token(c, ln, cl, pos);
      end
      M_DOTLEAD: begin
        if (is_digit_c(c)) mode = M_FRAC;
        else stop_at(open_line, open_column, open_offset);
      end
      M_DOTMID: begin
        if (is_digit_c(c)) mode = M_FRAC;
        else dot_stop(ln, cl, pos);
      end
      M_DQ, M_SQ: begin
        if (c == (mode == M_DQ ? "\"" : "'")) begin
          put_token(stt_pkg::KindString, open_line, open_column, open_offset,
                    span_of(open_offset, pos + 1));
          mode = M_IDLE;
        end else if (c == "\\") begin
          mode = mode == M_DQ ? M_DQESC : M_SQESC;
        end
      end
      M_DQESC: mode = M_DQ;
      M_SQESC: mode = M_SQ;
      M_COMMENT: begin
        if (c == "\n") mode = M_IDLE;
      end
      M_OP: begin
        if (c == op_tail[op_id]) begin
          if (op_pair_kind[op_id] == PairComment) begin
            mode = M_COMMENT;
          end else begin
            put_token(op_pair_kind[op_id], open_line, open_column, open_offset, 2);
            mode = M_IDLE;
          end
        end else if (open_kind == stt_pkg::KindErr) begin
          stop_at(open_line, open_column, open_offset);
        end else begin
          put_token(open_kind, open_line, open_column, open_offset, 1);
          open_token(c, ln, cl, pos);
        end
      end
      default: begin
        // Identifier, possibly still tracking a keyword prefix.
        if (is_digit_c(c) || is_alpha_c(c)) begin
          if (kw_id >= 0) begin
            m = kw_follow(kw_id, kw_pos, c);
            if (m >= 0) begin
              kw_id = m;
              kw_pos++;
              return;
            end
          end
          kw_id = -1;
          return;
        end
        put_token(word_kind(), open_line, open_column, open_offset,
                  span_of(open_offset, pos));
        open_token(c, ln, cl, pos);
      end
    endcase
  endtask

  task automatic close_text();
    case (mode)
      M_INT, M_FRAC: put_token(stt_pkg::KindNumber, open_line, open_column, open_offset,
                               span_of(open_offset, pos_offset));
      M_DOTMID: dot_stop(pos_line, pos_column, pos_offset);
      M_DOTLEAD, M_DQ, M_DQESC, M_SQ, M_SQESC: stop_at(open_line, open_column, open_offset);
      M_OP: begin
        if (open_kind == stt_pkg::KindErr) stop_at(open_line, open_column, open_offset);
        else put_token(open_kind, open_line, open_column, open_offset, 1);
      end
      M_WORD: put_token(word_kind(), open_line, open_column, open_offset,
                        span_of(open_offset, pos_offset));
      default: ;
    endcase
    if (halted) return;
    put_token(stt_pkg::KindEnd, pos_line, pos_column, pos_offset, 0);
    halted = 1;
    mode = M_IDLE;
  endtask

  // Predicts the tokens that one accepted byte releases and queues them.
  task automatic predict_tokens(int c, bit last, int row);
    if (halted) return;
    step_tokens.delete();
    consume_byte(c);
    if (c == "\n") begin
      if (pos_line < LineMax) pos_line++;
      pos_column = 1;
    end else if (pos_column < ColumnMax) begin
      pos_column++;
    end
    if (pos_offset < OffsetMax) pos_offset++;
    if (!halted && last) close_text();
    if (step_tokens.size() == 0) return;
    step_tokens[step_tokens.size() - 1].last = 1;
    // Directed fragments also state the first token they yield.
    if (row >= 0 && !row_checked.exists(row)) begin
      row_checked[row] = 1;
      if (step_tokens[0].kind != fragments[row].first_kind ||
          step_tokens[0].length != 24'(fragments[row].first_len)) begin
        errors++;
        if (errors <= 10)
          $display("Fragment %0d: first token kind %0d len %0d, table says %0d len %0d",
                   row, step_tokens[0].kind, step_tokens[0].length,
                   fragments[row].first_kind, fragments[row].first_len);
      end
    end
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endtask

  task automatic add_byte(int c, int row);
    src_byte_t b;
    b.code = c[7:0];
    b.last = 0;
    b.row = row;
    source_bytes.push_back(b);
  endtask

  task automatic add_text(string s, int row);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], row);
  endtask

  function automatic int word_char();
    case ($urandom_range(3))
      0: return $urandom_range("a", "z");
      1: return $urandom_range("A", "Z");
      2: return $urandom_range("0", "9");
      default: return "_";
    endcase
  endfunction

  // One well-formed random token; adjacent tokens may merge, which is still legal text.
  task automatic add_random_token();
    int q, n, b;
    case ($urandom_range(11))
      0: begin
        n = $urandom_range(1, 4);
        repeat (n) add_byte($urandom_range("0", "9"), -1);
        if ($urandom_range(1)) begin
          add_byte(".", -1);
          repeat ($urandom_range(1, 3)) add_byte($urandom_range("0", "9"), -1);
        end
      end
      1, 2: add_text(kw_word[$urandom_range(12)], -1);
      3: begin
        add_byte(is_alpha_c("a") ? $urandom_range("a", "z") : "a", -1);
        repeat ($urandom_range(0, 5)) add_byte(word_char(), -1);
      end
      4: begin
        q = $urandom_range(1) ? "\"" : "'";
        add_byte(q, -1);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(4) == 0) begin
            add_byte("\\", -1);
            add_byte($urandom_range(255), -1);
          end else begin
            do b = $urandom_range(255); while (b == q || b == "\\");
            add_byte(b, -1);
          end
        end
        add_byte(q, -1);
      end
      5, 6: begin
        n = $urandom_range(8);
        add_byte(op_lead[n], -1);
        if (n >= 6 || $urandom_range(1)) add_byte(op_tail[n], -1);
      end
      7: add_byte(punct_chars[$urandom_range(8)], -1);
      8: begin
        add_text("//", -1);
        repeat ($urandom_range(0, 5)) begin
          do b = $urandom_range(255); while (b == "\n");
          add_byte(b, -1);
        end
        add_byte("\n", -1);
      end
      9: add_byte("\n", -1);
      default: add_byte(".", -1);
    endcase
    // A lone dot must lead a fraction.
    if (source_bytes[source_bytes.size() - 1].code == ".")
      add_byte($urandom_range("0", "9"), -1);
    case ($urandom_range(3))
      0: ;
      1: add_byte("\t", -1);
      default: add_byte(" ", -1);
    endcase
  endtask

  // The text ends normally or on one of the ways the scanner gives up.
  task automatic add_ending();
    int unsigned pick;
    int bad [6] = '{0, 255, 13, "#", "@", 128};
    add_byte(" ", -1);
    case ($urandom_range(4))
      0: add_text("ok", -1);
      1: begin
        pick = $urandom_range(6);
        add_byte(pick == 6 ? $urandom_range(128, 255) : bad[pick], -1);
      end
      2: add_text("\"open\\", -1);
      3: add_text("7.x", -1);
      default: add_text(": ", -1);
    endcase
    source_bytes[source_bytes.size() - 1].last = 1;
    // A halted block takes bytes but releases nothing.
    repeat (4) add_byte($urandom_range(255), -1);
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Compare released tokens and predict on accepted bytes.
  always @(posedge clk) begin
    token_t want;
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_bus.valid && in_bus.ready) begin
        predict_tokens(in_bus.char_code, in_bus.end_of_text,
                       source_bytes[accepted_bytes].row);
        accepted_bytes <= accepted_bytes + 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_tokens.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected token kind %0d at offset %0d",
                     out_bus.token_kind, out_bus.start_offset);
        end else begin
          want = pending_tokens.pop_front();
          if (out_bus.token_kind !== want.kind || out_bus.start_line !== want.line ||
              out_bus.start_column !== want.column || out_bus.start_offset !== want.offset ||
              out_bus.token_length !== want.length || out_bus.last_of_run !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("Token mismatch: expected k%0d %0d:%0d off %0d len %0d last %0d,",
                       want.kind, want.line, want.column, want.offset, want.length,
                       want.last,
                       " got k%0d %0d:%0d off %0d len %0d last %0d",
                       out_bus.token_kind, out_bus.start_line,
                       out_bus.start_column, out_bus.start_offset, out_bus.token_length,
                       out_bus.last_of_run);
          end
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off.
  initial begin
    int hold_cycles;
    out_bus.ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_bus.ready <= 0;
        hold_cycles = 0;
        while (hold_cycles < 120) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_receiver = 0;
      end
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Sender and end-of-run control.
  initial begin
    int total, phase, wait_cycles;
    in_bus.valid = 0;
    in_bus.char_code = 0;
    in_bus.end_of_text = 0;
    rst_n = 0;
    mode = M_IDLE;
    kw_id = -1;
    kw_pos = 0;
    op_id = 0;
    open_kind = stt_pkg::KindNumber;
    open_line = 1;
    open_column = 1;
    open_offset = 0;
    pos_line = 1;
    pos_column = 1;
    pos_offset = 0;
    halted = 0;

    foreach (fragments[r]) add_text(fragments[r].text, r);
    while (source_bytes.size() < SourceBytes) add_random_token();
    add_ending();
    total = source_bytes.size();

    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    for (int i = 0; i < total; i++) begin
      phase = i * 4 / total;
      idle_pct = phase == 1 ? 67 : (phase == 3 ? 17 : 0);
      stall_pct = phase == 2 ? 67 : (phase == 3 ? 17 : 0);
      if (i == total / 3) hold_receiver = 1;
      while ($urandom_range(99) < idle_pct) begin
        in_bus.valid <= 0;
        @(posedge clk);
      end
      in_bus.valid <= 1;
      in_bus.char_code <= source_bytes[i].code;
      in_bus.end_of_text <= source_bytes[i].last;
      @(posedge clk);
      while (!in_bus.ready) @(posedge clk);
    end
    in_bus.valid <= 0;
    sender_done = 1;
  end

  // Drain, then settle and report.
  initial begin
    @(posedge rst_n);
    while (!(sender_done && pending_tokens.size() == 0) && quiet_cycles < WatchdogLimit)
      @(posedge clk);
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      if (errors == 0 && pending_tokens.size() == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
      $finish;
    end
  end

endmodule
